// ===== rtl/mcfp_pkg.sv =====
// Package for the motor command frame parser: payload structs, status and
// kind codes, register indexes and fixed constants. No dependencies.
`default_nettype none
package mcfp_pkg;

   typedef struct packed {
      logic [7:0] packet_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] taken_value;
      logic signed [31:0] target_value;
      logic [1:0]         value_kind;
      logic               command_new;
      logic [7:0]         entry_count;
   } rsp_type;

   localparam logic [2:0] ST_SINGLE  = 3'd0;
   localparam logic [2:0] ST_SLICE   = 3'd1;
   localparam logic [2:0] ST_LEGACY  = 3'd2;
   localparam logic [2:0] ST_STRUCT  = 3'd3;
   localparam logic [2:0] ST_UNKNOWN = 3'd4;
   localparam logic [2:0] ST_NOTME   = 3'd5;
   localparam logic [2:0] ST_BAD     = 3'd6;

   localparam logic [1:0] KIND_ANGLE    = 2'd0;
   localparam logic [1:0] KIND_VELOCITY = 2'd1;
   localparam logic [1:0] KIND_CURRENT  = 2'd2;

   localparam logic [2:0] REG_DEVICE_ID  = 3'd0;
   localparam logic [2:0] REG_ANGLE_RCP  = 3'd1;
   localparam logic [2:0] REG_VEL_RCP    = 3'd2;
   localparam logic [2:0] REG_VEL_CODE   = 3'd3;
   localparam logic [2:0] REG_CUR_CODE   = 3'd4;
   localparam logic [2:0] REG_MOTOR_LIM  = 3'd5;
   localparam logic [2:0] REG_THRESHOLD  = 3'd6;

   localparam logic [7:0] HDR0        = 8'hAA;
   localparam logic [7:0] HDR1        = 8'h55;
   localparam logic [7:0] TYPE_SINGLE = 8'h01;
   localparam logic [7:0] TYPE_MULTI  = 8'h02;
   localparam logic [7:0] TYPE_STRUCT = 8'h03;

   // 1/1000 in Q0.24
   localparam logic [23:0] CURRENT_RECIP = 24'd16777;
   localparam int          LEGACY_LEN    = 24;

endpackage
`default_nettype wire

// ===== rtl/motor_command_frame_parser_core.sv =====
// Motor command frame parser top level: byte capture, end-of-packet decode,
// scaling multiply and target update. Depends on mcfp_pkg.
//
// Path: the last byte's decode is registered into the decode stage, then the
// multiply stage, then the result register, which drives rsp_valid.
// Throughput: one byte per cycle while rsp_ready is high; a stalled result backs
// up into the decode and multiply stages, and req_ready drops once all three hold.
// Reset: synchronous, active high; clears position, scan state, target, flag,
// kind and pipeline valids, and reloads registers with their defaults.
`default_nettype none
module motor_command_frame_parser_core #(
   parameter int MAX_PACKET_BYTES = 1024,
   parameter int LEGACY_SLOTS     = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire mcfp_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output mcfp_pkg::rsp_type      rsp_payload,
   input  wire logic              csr_valid,
   output logic                   csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_data
);

   localparam int POS_W = $clog2(MAX_PACKET_BYTES + 2);
   localparam logic [POS_W-1:0] POS_MAX  = POS_W'(MAX_PACKET_BYTES);
   localparam logic [POS_W-1:0] POS_SAT  = POS_W'(MAX_PACKET_BYTES + 1);
   localparam logic [POS_W-1:0] POS_LEG  = POS_W'(mcfp_pkg::LEGACY_LEN);
   localparam logic [7:0]       SLOTS    = 8'(LEGACY_SLOTS);

   typedef struct packed {
      logic [2:0]         status;
      logic signed [15:0] raw;
      logic [7:0]         cnt;
      logic [23:0]        recip;
      logic               apply;
      logic               clear_flag;
      logic               set_kind;
      logic [1:0]         kind;
   } dec_type;

   // configuration
   logic [7:0]  device_id_ff, vel_code_ff, cur_code_ff, motor_lim_ff;
   logic [23:0] angle_rcp_ff, vel_rcp_ff;
   logic [15:0] threshold_ff;

   // capture state
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       head_ff [7];
   logic [7:0]       head_in [7];
   logic [15:0]      slice_ff, slice_in, legacy_ff, legacy_in, smv_ff, smv_in;
   logic             found_ff, found_in;
   logic [7:0]       eidx_ff, eidx_in, ehold_ff, ehold_in;
   logic [1:0]       eph_ff, eph_in;

   // pipeline
   logic        s1_valid_ff, s2_valid_ff, rsp_valid_ff;
   dec_type     s1_ff, s1_in, s2_ff;
   logic signed [40:0] prod_ff, prod_in;
   mcfp_pkg::rsp_type  rsp_ff, rsp_in;

   logic signed [31:0] target_ff, target_in;
   logic        flag_ff, flag_in;
   logic [1:0]  kind_ff, kind_in;

   logic req_fire, rsp_load, s2_free, s1_free, is_last;

   assign is_last   = req_payload.last_byte;
   assign rsp_load  = s2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign s2_free   = !s2_valid_ff || rsp_load;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // byte capture and end-of-packet decode
   always_comb begin
      logic [POS_W-1:0] p, len, slot;
      logic [7:0] b, cnt8, start, count, tb, dt, idb;
      logic [8:0] range_end;
      logic       hdr, pass;
      logic [POS_W:0] need;
      b        = req_payload.packet_byte;
      p        = pos_ff;
      slot     = '0;
      head_in  = head_ff;
      slice_in = slice_ff;
      legacy_in = legacy_ff;
      smv_in   = smv_ff;
      found_in = found_ff;
      eidx_in  = eidx_ff;
      eph_in   = eph_ff;
      ehold_in = ehold_ff;
      hdr = head_ff[0] == mcfp_pkg::HDR0 && head_ff[1] == mcfp_pkg::HDR1 &&
            (head_ff[2] == mcfp_pkg::TYPE_SINGLE || head_ff[2] == mcfp_pkg::TYPE_MULTI ||
             head_ff[2] == mcfp_pkg::TYPE_STRUCT);
      cnt8 = hdr ? head_ff[4] : head_ff[2];
      pass = 1'b0;
      if (p < POS_MAX) begin
         pos_in = p + POS_W'(1);
         for (int i = 0; i < 7; i++) begin
            if (p == POS_W'(i)) head_in[i] = b;
         end
         if (p >= POS_W'(6) && device_id_ff >= head_ff[4]) begin
            slot = (p - POS_W'(6)) >> 1;
            if (slot == POS_W'(device_id_ff - head_ff[4])) begin
               if (p[0]) slice_in[7:0] = b;
               else slice_in[15:8] = b;
            end
         end
         if (p >= POS_W'(4) && device_id_ff >= 8'd1) begin
            slot = (p - POS_W'(4)) >> 1;
            if (slot == POS_W'(device_id_ff - 8'd1)) begin
               if (p[0]) legacy_in[7:0] = b;
               else legacy_in[15:8] = b;
            end
         end
         pass = p >= (hdr ? POS_W'(5) : POS_W'(3));
         if (pass && !found_ff && eidx_ff < cnt8) begin
            unique case (eph_ff)
               2'd0: begin
                  ehold_in = b;
                  eph_in = 2'd1;
               end
               2'd1: begin
                  if (ehold_ff == device_id_ff) smv_in[15:8] = b;
                  eph_in = 2'd2;
               end
               default: begin
                  if (ehold_ff == device_id_ff) begin
                     smv_in[7:0] = b;
                     found_in = 1'b1;
                  end
                  eph_in = 2'd0;
                  eidx_in = eidx_ff + 8'd1;
               end
            endcase
         end
      end else begin
         pos_in = POS_SAT;
      end

      // decode on post-capture state
      len = pos_in;
      s1_in = '0;
      s1_in.status = mcfp_pkg::ST_UNKNOWN;
      s1_in.recip = angle_rcp_ff;
      hdr = head_in[0] == mcfp_pkg::HDR0 && head_in[1] == mcfp_pkg::HDR1 &&
            (head_in[2] == mcfp_pkg::TYPE_SINGLE || head_in[2] == mcfp_pkg::TYPE_MULTI ||
             head_in[2] == mcfp_pkg::TYPE_STRUCT);
      tb    = hdr ? head_in[2] : head_in[0];
      dt    = hdr ? head_in[3] : head_in[1];
      start = head_in[4];
      count = head_in[5];
      idb   = hdr ? head_in[4] : head_in[1];
      range_end = {1'b0, start} + {1'b0, count} - 9'd1;
      need = '0;
      if (dt == vel_code_ff) begin
         s1_in.kind = mcfp_pkg::KIND_VELOCITY;
         s1_in.recip = vel_rcp_ff;
      end else if (dt == cur_code_ff) begin
         s1_in.kind = mcfp_pkg::KIND_CURRENT;
         s1_in.recip = mcfp_pkg::CURRENT_RECIP;
      end else begin
         s1_in.kind = mcfp_pkg::KIND_ANGLE;
      end
      if (len < POS_W'(3) || len > POS_MAX) begin
         s1_in.status = mcfp_pkg::ST_BAD;
      end else if (tb == mcfp_pkg::TYPE_SINGLE) begin
         s1_in.recip = angle_rcp_ff;
         if (len < (hdr ? POS_W'(7) : POS_W'(6))) begin
            s1_in.status = mcfp_pkg::ST_BAD;
         end else if (idb != device_id_ff) begin
            s1_in.status = mcfp_pkg::ST_NOTME;
            s1_in.clear_flag = 1'b1;
         end else begin
            s1_in.status = mcfp_pkg::ST_SINGLE;
            s1_in.raw = hdr ? {head_in[5], head_in[6]} : {head_in[3], head_in[4]};
            s1_in.apply = 1'b1;
         end
      end else if (tb == mcfp_pkg::TYPE_MULTI) begin
         need = {1'b0, POS_W'(6)} + {{(POS_W-8){1'b0}}, count, 1'b0};
         if (hdr && len == POS_W'(3)) begin
            s1_in.status = mcfp_pkg::ST_BAD;
         end else begin
            s1_in.set_kind = 1'b1;
            if (hdr && len >= POS_W'(6) && start >= 8'd1 && start <= motor_lim_ff &&
                count >= 8'd1 && {1'b0, len} == need) begin
               s1_in.cnt = count;
               if (device_id_ff < start || {1'b0, device_id_ff} > range_end) begin
                  s1_in.status = mcfp_pkg::ST_NOTME;
               end else begin
                  s1_in.status = mcfp_pkg::ST_SLICE;
                  s1_in.raw = slice_in;
                  s1_in.apply = 1'b1;
               end
            end else if (hdr && len == POS_LEG) begin
               if (device_id_ff < 8'd1 || device_id_ff > SLOTS) begin
                  s1_in.status = mcfp_pkg::ST_NOTME;
               end else begin
                  s1_in.status = mcfp_pkg::ST_LEGACY;
                  s1_in.raw = legacy_in;
                  s1_in.apply = 1'b1;
               end
            end else begin
               s1_in.status = mcfp_pkg::ST_BAD;
            end
         end
      end else if (tb == mcfp_pkg::TYPE_STRUCT) begin
         cnt8 = hdr ? head_in[4] : head_in[2];
         need = (hdr ? (POS_W+1)'(5) : (POS_W+1)'(3)) + (POS_W+1)'(cnt8) * (POS_W+1)'(3);
         if (len < (hdr ? POS_W'(5) : POS_W'(3))) begin
            s1_in.status = mcfp_pkg::ST_BAD;
         end else begin
            s1_in.cnt = cnt8;
            s1_in.set_kind = 1'b1;
            if ({1'b0, len} < need) begin
               s1_in.status = mcfp_pkg::ST_BAD;
            end else if (!found_in) begin
               s1_in.status = mcfp_pkg::ST_NOTME;
            end else begin
               s1_in.status = mcfp_pkg::ST_STRUCT;
               s1_in.raw = smv_in;
               s1_in.apply = 1'b1;
            end
         end
      end
   end

   assign prod_in = s1_ff.raw * $signed({1'b0, s1_ff.recip});

   // round to Q15.16, compare with the stored target, update target, flag and kind, and build the result
   always_comb begin
      logic signed [40:0] rnd;
      logic signed [32:0] q;
      logic signed [33:0] d, ad;
      rnd = prod_ff + 41'sd128;
      q   = rnd[40:8];
      d   = 34'(q) - 34'(target_ff);
      ad  = d[33] ? -d : d;
      target_in = target_ff;
      flag_in   = flag_ff;
      kind_in   = s2_ff.set_kind ? s2_ff.kind : kind_ff;
      if (s2_ff.apply) begin
         if (ad > $signed({18'd0, threshold_ff})) begin
            target_in = q[31:0];
            flag_in = 1'b1;
         end else begin
            flag_in = 1'b0;
         end
      end else if (s2_ff.clear_flag) begin
         flag_in = 1'b0;
      end
      rsp_in.status       = s2_ff.status;
      rsp_in.taken_value  = s2_ff.apply ? s2_ff.raw : 16'sd0;
      rsp_in.target_value = target_in;
      rsp_in.value_kind   = kind_in;
      rsp_in.command_new  = flag_in;
      rsp_in.entry_count  = s2_ff.cnt;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         device_id_ff <= 8'd6;
         angle_rcp_ff <= 24'd167772;
         vel_rcp_ff   <= 24'd167772;
         vel_code_ff  <= 8'd1;
         cur_code_ff  <= 8'd2;
         motor_lim_ff <= 8'd10;
         threshold_ff <= 16'd66;
      end else if (csr_valid) begin
         unique case (csr_index)
            mcfp_pkg::REG_DEVICE_ID: device_id_ff <= csr_data[7:0];
            mcfp_pkg::REG_ANGLE_RCP: angle_rcp_ff <= csr_data;
            mcfp_pkg::REG_VEL_RCP:   vel_rcp_ff   <= csr_data;
            mcfp_pkg::REG_VEL_CODE:  vel_code_ff  <= csr_data[7:0];
            mcfp_pkg::REG_CUR_CODE:  cur_code_ff  <= csr_data[7:0];
            mcfp_pkg::REG_MOTOR_LIM: motor_lim_ff <= csr_data[7:0];
            mcfp_pkg::REG_THRESHOLD: threshold_ff <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff   <= '0;
         found_ff <= 1'b0;
         eidx_ff  <= '0;
         eph_ff   <= '0;
         ehold_ff <= '0;
      end else if (req_fire) begin
         if (is_last) begin
            pos_ff   <= '0;
            found_ff <= 1'b0;
            eidx_ff  <= '0;
            eph_ff   <= '0;
            ehold_ff <= '0;
         end else begin
            pos_ff   <= pos_in;
            found_ff <= found_in;
            eidx_ff  <= eidx_in;
            eph_ff   <= eph_in;
            ehold_ff <= ehold_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         head_ff   <= head_in;
         slice_ff  <= slice_in;
         legacy_ff <= legacy_in;
         smv_ff    <= smv_in;
      end
      if (req_fire && is_last) s1_ff <= s1_in;
      if (s1_valid_ff && s2_free) begin
         s2_ff   <= s1_ff;
         prod_ff <= prod_in;
      end
      if (rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         flag_ff      <= 1'b0;
         kind_ff      <= mcfp_pkg::KIND_ANGLE;
      end else begin
         if (req_fire && is_last) s1_valid_ff <= 1'b1;
         else if (s2_free) s1_valid_ff <= 1'b0;
         if (s2_free) s2_valid_ff <= s1_valid_ff;
         if (rsp_load) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
         if (rsp_load) begin
            target_ff <= target_in;
            flag_ff   <= flag_in;
            kind_ff   <= kind_in;
         end
      end
   end

   a_last_enters: assert property (@(posedge clock) disable iff (reset)
      req_fire && is_last |=> s1_valid_ff)
      else $error("last beat did not enter decode stage");
   a_pos_sat: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_SAT)
      else $error("byte position past saturation");
   a_phase: assert property (@(posedge clock) disable iff (reset)
      eph_ff != 2'd3)
      else $error("entry phase illegal");
   a_bad_raw: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status == mcfp_pkg::ST_BAD |-> rsp_ff.taken_value == 16'sd0)
      else $error("malformed result carries a value");

endmodule
`default_nettype wire

// ===== tb/motor_command_frame_parser_core_checker.sv =====
// Scoreboard for the motor command frame parser: watches req, rsp and csr beats,
// predicts each packet result and compares it field by field. Depends on mcfp_pkg.
`timescale 1ns / 1ps
module motor_command_frame_parser_core_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire mcfp_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire mcfp_pkg::rsp_type rsp_payload,
   input  wire logic              csr_valid,
   input  wire logic              csr_ready,
   input  wire logic [2:0]        csr_index,
   input  wire logic [23:0]       csr_data,
   output int                     fail_count,
   output int                     pending
);

   localparam int MAX_BYTES = 1024;
   localparam int SLOTS     = 10;

   logic [7:0]  r_dev, r_lim, r_vc, r_cc;
   logic [23:0] r_ar, r_vr;
   logic [15:0] r_th;

   logic signed [31:0] tgt;
   logic        flag;
   logic [1:0]  kind;
   int          pos;
   logic [7:0]  head [7];
   logic [15:0] slc, leg, smv;
   logic        sfound;
   logic [7:0]  eidx, eid;
   logic [1:0]  eph;

   mcfp_pkg::rsp_type result_q [$];
   int      mismatches;

   function automatic logic header_seen();
      return head[0] == mcfp_pkg::HDR0 && head[1] == mcfp_pkg::HDR1 &&
             (head[2] == mcfp_pkg::TYPE_SINGLE || head[2] == mcfp_pkg::TYPE_MULTI ||
              head[2] == mcfp_pkg::TYPE_STRUCT);
   endfunction

   task automatic put_half(inout logic [15:0] r, input int odd, input logic [7:0] b);
      if (odd != 0) r[7:0] = b;
      else r[15:8] = b;
   endtask

   task automatic take_value(input logic signed [15:0] raw, input logic [23:0] rcp);
      longint v, q, d;
      v = longint'(raw) * longint'(rcp) + 128;
      q = v >>> 8;
      d = q - longint'(tgt);
      if (d < 0) d = -d;
      if (d > longint'(r_th)) begin
         tgt  = q[31:0];
         flag = 1'b1;
      end else begin
         flag = 1'b0;
      end
   endtask

   function automatic logic [23:0] pick_scale(input logic [7:0] dt);
      if (dt == r_vc) begin
         kind = mcfp_pkg::KIND_VELOCITY;
         return r_vr;
      end
      if (dt == r_cc) begin
         kind = mcfp_pkg::KIND_CURRENT;
         return mcfp_pkg::CURRENT_RECIP;
      end
      kind = mcfp_pkg::KIND_ANGLE;
      return r_ar;
   endfunction

   task automatic capture(input int p, input logic [7:0] b);
      int   di, items, cnt;
      logic h;
      di = int'(r_dev);
      if (p < 7) head[p] = b;
      if (p >= 6 && di >= int'(head[4]))
         if (((p - 6) >> 1) == di - int'(head[4])) put_half(slc, (p - 6) & 1, b);
      if (p >= 4 && di >= 1)
         if (((p - 4) >> 1) == di - 1) put_half(leg, (p - 4) & 1, b);
      if (p >= 3) begin
         h     = header_seen();
         items = h ? 5 : 3;
         cnt   = h ? int'(head[4]) : int'(head[2]);
         if (p >= items && !sfound && int'(eidx) < cnt) begin
            if (eph == 2'd0) begin
               eid = b;
               eph = 2'd1;
            end else if (eph == 2'd1) begin
               if (eid == r_dev) put_half(smv, 0, b);
               eph = 2'd2;
            end else begin
               if (eid == r_dev) begin
                  put_half(smv, 1, b);
                  sfound = 1'b1;
               end
               eph  = 2'd0;
               eidx = eidx + 8'd1;
            end
         end
      end
   endtask

   task automatic decode_packet(input int len, output logic [2:0] st,
                                output logic [15:0] raw, output logic [7:0] cnt);
      logic        h;
      logic [7:0]  ptype;
      logic [23:0] rcp;
      int          toff, idoff, voff, start, count, items, di;
      raw = '0;
      cnt = '0;
      di  = int'(r_dev);
      if (len < 3 || len > MAX_BYTES) begin
         st = mcfp_pkg::ST_BAD;
         return;
      end
      h     = header_seen();
      ptype = h ? head[2] : head[0];
      toff  = h ? 3 : 1;
      if (ptype == mcfp_pkg::TYPE_SINGLE) begin
         idoff = h ? 4 : 1;
         voff  = h ? 5 : 3;
         if (len < (h ? 7 : 6)) st = mcfp_pkg::ST_BAD;
         else if (head[idoff] != r_dev) begin
            flag = 1'b0;
            st   = mcfp_pkg::ST_NOTME;
         end else begin
            raw = {head[voff], head[voff+1]};
            take_value(raw, r_ar);
            st = mcfp_pkg::ST_SINGLE;
         end
      end else if (ptype == mcfp_pkg::TYPE_MULTI) begin
         if (len <= toff) begin
            st = mcfp_pkg::ST_BAD;
            return;
         end
         rcp = pick_scale(head[toff]);
         if (h && len >= 6) begin
            start = int'(head[4]);
            count = int'(head[5]);
            if (start >= 1 && start <= int'(r_lim) && count >= 1 && len == 6 + 2 * count) begin
               cnt = count[7:0];
               // range end is not wrapped to 8 bits
               if (di < start || di > start + count - 1) st = mcfp_pkg::ST_NOTME;
               else begin
                  raw = slc;
                  take_value(raw, rcp);
                  st = mcfp_pkg::ST_SLICE;
               end
               return;
            end
         end
         if (h && len == mcfp_pkg::LEGACY_LEN) begin
            if (di < 1 || di > SLOTS) st = mcfp_pkg::ST_NOTME;
            else begin
               raw = leg;
               take_value(raw, rcp);
               st = mcfp_pkg::ST_LEGACY;
            end
         end else begin
            st = mcfp_pkg::ST_BAD;
         end
      end else if (ptype == mcfp_pkg::TYPE_STRUCT) begin
         items = toff + 2;
         if (len < items) begin
            st = mcfp_pkg::ST_BAD;
            return;
         end
         count = int'(head[toff+1]);
         cnt   = count[7:0];
         rcp   = pick_scale(head[toff]);
         if (len < items + 3 * count) st = mcfp_pkg::ST_BAD;
         else if (!sfound) st = mcfp_pkg::ST_NOTME;
         else begin
            raw = smv;
            take_value(raw, rcp);
            st = mcfp_pkg::ST_STRUCT;
         end
      end else begin
         st = mcfp_pkg::ST_UNKNOWN;
      end
   endtask

   task automatic clear_scan();
      pos    = 0;
      sfound = 1'b0;
      eidx   = '0;
      eph    = '0;
      eid    = '0;
   endtask

   always @(posedge clock) begin
      mcfp_pkg::rsp_type e, got;
      logic [2:0]  st;
      logic [15:0] raw;
      logic [7:0]  cnt;
      if (reset) begin
         r_dev = 8'd6;
         r_ar  = 24'd167772;
         r_vr  = 24'd167772;
         r_vc  = 8'd1;
         r_cc  = 8'd2;
         r_lim = 8'd10;
         r_th  = 16'd66;
         tgt   = '0;
         flag  = 1'b0;
         kind  = mcfp_pkg::KIND_ANGLE;
         for (int i = 0; i < 7; i++) head[i] = '0;
         slc = '0;
         leg = '0;
         smv = '0;
         clear_scan();
         result_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mcfp_pkg::REG_DEVICE_ID: r_dev = csr_data[7:0];
               mcfp_pkg::REG_ANGLE_RCP: r_ar  = csr_data;
               mcfp_pkg::REG_VEL_RCP:   r_vr  = csr_data;
               mcfp_pkg::REG_VEL_CODE:  r_vc  = csr_data[7:0];
               mcfp_pkg::REG_CUR_CODE:  r_cc  = csr_data[7:0];
               mcfp_pkg::REG_MOTOR_LIM: r_lim = csr_data[7:0];
               mcfp_pkg::REG_THRESHOLD: r_th  = csr_data[15:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (pos < MAX_BYTES) begin
               capture(pos, req_payload.packet_byte);
               pos++;
            end else begin
               pos = MAX_BYTES + 1;
            end
            if (req_payload.last_byte) begin
               decode_packet(pos, st, raw, cnt);
               e.status       = st;
               e.taken_value  = raw;
               e.target_value = tgt;
               e.value_kind   = kind;
               e.command_new  = flag;
               e.entry_count  = cnt;
               result_q.push_back(e);
               clear_scan();
            end
         end
         if (rsp_valid && rsp_ready) begin
            got = rsp_payload;
            if (result_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: expected no result, got %p", got);
            end else begin
               e = result_q.pop_front();
               if (got.status !== e.status || got.taken_value !== e.taken_value ||
                   got.target_value !== e.target_value || got.value_kind !== e.value_kind ||
                   got.command_new !== e.command_new || got.entry_count !== e.entry_count) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: expected %p, got %p", e, got);
               end
            end
         end
      end
      fail_count <= mismatches;
      pending    <= result_q.size();
   end

endmodule

// ===== tb/motor_command_frame_parser_core_tb.sv =====
// Top of the motor command frame parser testbench: clock, reset, packet and
// register stimulus, verdict. Depends on mcfp_pkg, the core and the checker.
`timescale 1ns / 1ps
module motor_command_frame_parser_core_tb;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int RANDOM_BYTES = 1550;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   mcfp_pkg::req_type req_payload;
   logic        rsp_valid;
   logic        rsp_ready;
   mcfp_pkg::rsp_type rsp_payload;
   logic        csr_valid;
   logic        csr_ready;
   logic [2:0]  csr_index;
   logic [23:0] csr_data;
   int          fail_count;
   int          pending;
   int          cycles;
   int          sent_bytes;
   int          rsp_wait;
   int          rsp_draw;
   logic        burst;
   logic [7:0]  pkt [$];
   logic [7:0]  dev, lim, vcode, ccode;

   motor_command_frame_parser_core u_top (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   motor_command_frame_parser_core_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_payload(req_payload),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_payload(rsp_payload),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // result side: a fresh stall drawn after each beat, often none
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else if (rsp_wait > 0) begin
         rsp_ready <= (rsp_wait == 1);
         rsp_wait  <= rsp_wait - 1;
      end else if (rsp_valid && rsp_ready) begin
         rsp_draw   = ($urandom % 3 == 0) ? 0 : int'($urandom_range(0, 17));
         rsp_ready <= (rsp_draw == 0);
         rsp_wait  <= rsp_draw;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic send_beat(input logic [7:0] b, input logic l);
      int gap;
      gap = burst ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= {b, l};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_bytes++;
   endtask

   task automatic send_pkt();
      burst = ($urandom % 4 == 0);
      for (int i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == pkt.size() - 1);
      pkt.delete();
   endtask

   // sender holds off until every result is back, then lets the pipe drain
   task automatic wait_idle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic set_regs(input logic [7:0] d, input logic [23:0] ar, input logic [23:0] vr,
                           input logic [7:0] vc, input logic [7:0] cc, input logic [7:0] ml,
                           input logic [15:0] th);
      wait_idle();
      csr_write(mcfp_pkg::REG_DEVICE_ID, {16'd0, d});
      csr_write(mcfp_pkg::REG_ANGLE_RCP, ar);
      csr_write(mcfp_pkg::REG_VEL_RCP, vr);
      csr_write(mcfp_pkg::REG_VEL_CODE, {16'd0, vc});
      csr_write(mcfp_pkg::REG_CUR_CODE, {16'd0, cc});
      csr_write(mcfp_pkg::REG_MOTOR_LIM, {16'd0, ml});
      csr_write(mcfp_pkg::REG_THRESHOLD, {8'd0, th});
      csr_valid <= 1'b0;
      dev   = d;
      vcode = vc;
      ccode = cc;
      lim   = ml;
   endtask

   task automatic random_regs(input int phase);
      logic [7:0]  d, ml, vc, cc;
      logic [23:0] ar, vr;
      logic [15:0] th;
      case ($urandom % 5)
         0: d = 8'd0;
         1: d = 8'd255;
         2: d = 8'($urandom);
         default: d = 8'($urandom_range(1, 10));
      endcase
      case ($urandom % 4)
         0: ar = 24'd1;
         1: ar = 24'hFFFFFF;
         default: ar = 24'($urandom);
      endcase
      case ($urandom % 4)
         0: vr = 24'd1;
         1: vr = 24'hFFFFFF;
         default: vr = 24'($urandom);
      endcase
      vc = ($urandom % 4 == 0) ? 8'hFF : 8'($urandom);
      cc = ($urandom % 6 == 0) ? vc : (($urandom % 4 == 0) ? 8'h00 : 8'($urandom));
      case ($urandom % 4)
         0: ml = 8'd1;
         1: ml = 8'd255;
         default: ml = 8'($urandom);
      endcase
      case (phase % 3)
         0: th = 16'd0;
         1: th = 16'hFFFF;
         default: th = 16'($urandom);
      endcase
      set_regs(d, ar, vr, vc, cc, ml, th);
   endtask

   function automatic logic [7:0] pick_code();
      case ($urandom % 3)
         0: return vcode;
         1: return ccode;
         default: return 8'($urandom);
      endcase
   endfunction

   task automatic gen_single();
      logic [7:0] id;
      int         len;
      id = ($urandom % 4 == 0) ? 8'($urandom) : dev;
      if ($urandom % 2) begin
         pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, mcfp_pkg::TYPE_SINGLE, 8'($urandom), id,
                 8'($urandom), 8'($urandom)};
         len = 7;
      end else begin
         pkt = '{mcfp_pkg::TYPE_SINGLE, id, 8'($urandom), 8'($urandom), 8'($urandom),
                 8'($urandom)};
         len = 6;
      end
      if ($urandom % 6 == 0) len = $urandom_range(3, len + 4);
      while (pkt.size() > len) void'(pkt.pop_back());
      while (pkt.size() < len) pkt.push_back(8'($urandom));
   endtask

   task automatic gen_slice();
      int start, count, len;
      if ($urandom % 5 == 0) start = $urandom_range(0, 255);
      else if ($urandom % 2) start = $urandom_range(1, dev > 0 ? dev : 1);
      else start = $urandom_range(1, lim);
      case ($urandom % 30)
         0: count = 0;
         1: count = $urandom_range(9, 255);
         default: count = $urandom_range(1, 8);
      endcase
      len = 6 + 2 * count;
      if ($urandom % 6 == 0) len = len + ($urandom % 2 ? 1 : -1);
      pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, mcfp_pkg::TYPE_MULTI, pick_code(), 8'(start),
              8'(count)};
      while (pkt.size() > len) void'(pkt.pop_back());
      while (pkt.size() < len) pkt.push_back(8'($urandom));
   endtask

   task automatic gen_legacy();
      int len;
      len = ($urandom % 8 == 0) ? $urandom_range(23, 25) : mcfp_pkg::LEGACY_LEN;
      pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, mcfp_pkg::TYPE_MULTI, pick_code()};
      while (pkt.size() < len) pkt.push_back(8'($urandom));
   endtask

   task automatic gen_struct();
      int count, len;
      count = $urandom_range(0, 6);
      if ($urandom % 2)
         pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, mcfp_pkg::TYPE_STRUCT, pick_code(), 8'(count)};
      else pkt = '{mcfp_pkg::TYPE_STRUCT, pick_code(), 8'(count)};
      for (int i = 0; i < count; i++) begin
         pkt.push_back(($urandom % 3 == 0) ? dev : 8'($urandom));
         pkt.push_back(8'($urandom));
         pkt.push_back(8'($urandom));
      end
      len = pkt.size();
      if ($urandom % 8 == 0) len = $urandom_range(1, len);
      else if ($urandom % 8 == 0) len = len + $urandom_range(1, 4);
      while (pkt.size() > len) void'(pkt.pop_back());
      while (pkt.size() < len) pkt.push_back(8'($urandom));
   endtask

   task automatic gen_noise(input int maxlen);
      int len;
      len = $urandom_range(1, maxlen);
      for (int i = 0; i < len; i++) pkt.push_back(8'($urandom));
   endtask

   initial begin
      int phase, phase_bytes, sel;
      logic overlong_done;
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_payload = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;
      sent_bytes  = 0;
      burst       = 1'b0;
      dev = 8'd6; lim = 8'd10; vcode = 8'd1; ccode = 8'd2;
      overlong_done = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: value extremes, both single layouts, short, unknown, struct
      set_regs(8'd6, 24'd167772, 24'd167772, 8'd1, 8'd2, 8'd10, 16'd66);
      pkt = '{mcfp_pkg::TYPE_SINGLE, 8'd6, 8'h00, 8'h7F, 8'hFF, 8'h00};
      send_pkt();
      pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, mcfp_pkg::TYPE_SINGLE, 8'h00, 8'd6, 8'h80, 8'h00};
      send_pkt();
      pkt = '{mcfp_pkg::TYPE_SINGLE, 8'd6};
      send_pkt();
      pkt = '{8'h00, 8'hFF, 8'h00};
      send_pkt();
      pkt = '{mcfp_pkg::TYPE_STRUCT, 8'd1, 8'd1, 8'd6, 8'h12, 8'h34};
      send_pkt();

      phase = 0;
      sent_bytes = 0;
      while (sent_bytes < RANDOM_BYTES) begin
         random_regs(phase);
         phase_bytes = sent_bytes;
         while (sent_bytes - phase_bytes < 200 && sent_bytes < RANDOM_BYTES) begin
            sel = $urandom % 20;
            if (sel < 4) gen_single();
            else if (sel < 8) gen_slice();
            else if (sel < 11) gen_legacy();
            else if (sel < 15) gen_struct();
            else if (sel < 17) gen_noise(30);
            else if (sel == 17) begin
               pkt.push_back(8'($urandom_range(4, 255)));
               gen_noise(10);
            end else if (sel == 18) gen_noise(2);
            else begin
               pkt = '{mcfp_pkg::HDR0, mcfp_pkg::HDR1, 8'($urandom_range(0, 4))};
               gen_noise(12);
            end
            send_pkt();
         end
         if (!overlong_done && phase == 2) begin
            pkt.push_back(mcfp_pkg::TYPE_SINGLE);
            pkt.push_back(dev);
            for (int i = 0; i < 1024; i++) pkt.push_back(8'($urandom));
            send_pkt();
            overlong_done = 1'b1;
         end
         phase++;
      end

      wait_idle();
      repeat (10) @(posedge clock);
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule
